// ===== hw/rtl/flr_pkg.sv =====
// shared types and codes for the fault event ring log
`timescale 1ns / 1ps
`default_nettype none

package flr_pkg;

    localparam int PEND_W = 4;

    typedef enum logic [1:0] {
        ACT_RECORD = 2'd0,
        ACT_POP    = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    typedef struct packed {
        logic [3:0]  module_id;
        logic [2:0]  severity;
        logic [7:0]  fault_code;
        logic [31:0] payload;
        logic [31:0] now_ms;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              pop_valid;
        logic [3:0]        popped_module;
        logic [2:0]        popped_severity;
        logic [7:0]        popped_code;
        logic [31:0]       popped_payload;
        logic [31:0]       popped_time;
        logic [PEND_W-1:0] pending;
        logic [31:0]       dropped;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/flr_if.sv =====
// request and result channel interfaces of the fault event ring log
`timescale 1ns / 1ps
`default_nettype none

interface flr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  module_id;
    logic [2:0]  severity;
    logic [7:0]  fault_code;
    logic [31:0] payload;
    logic [31:0] now_ms;

    modport source (output valid, action, module_id, severity, fault_code, payload, now_ms,
                    input ready);
    modport sink (input valid, action, module_id, severity, fault_code, payload, now_ms,
                  output ready);
endinterface

interface flr_rsp_if;
    logic        valid;
    logic        ready;
    logic        pop_valid;
    logic [3:0]  popped_module;
    logic [2:0]  popped_severity;
    logic [7:0]  popped_code;
    logic [31:0] popped_payload;
    logic [31:0] popped_time;
    logic [3:0]  pending;
    logic [31:0] dropped;

    modport source (output valid, pop_valid, popped_module, popped_severity, popped_code,
                    popped_payload, popped_time, pending, dropped,
                    input ready);
    modport sink (input valid, pop_valid, popped_module, popped_severity, popped_code,
                  popped_payload, popped_time, pending, dropped,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fault_log_ring_drop_oldest.sv =====
// fault event ring log top level: pointers, drop counter, control and result register
// results: record, clear and empty pop give their result in the cycle after the request;
// an entry pop is registered in the memory read data, then in the result register
// throughput: one request per cycle unless a pop read is pending or the result stalls
// reset: synchronous active low; clears pointers, count and drop counter, memory untouched
`timescale 1ns / 1ps
`default_nettype none

module fault_log_ring_drop_oldest
    import flr_pkg::*;
#(
    parameter int LOG_DEPTH = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    flr_req_if.sink   i_req,
    flr_rsp_if.source o_rsp
);

    localparam int PW = $clog2(LOG_DEPTH);
    localparam logic [PW-1:0] LAST = PW'(LOG_DEPTH - 1);

    t_state        r_state, n_state;
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [PW-1:0] r_count, n_count;
    logic [31:0]   r_drop, n_drop;
    logic          r_out_valid, n_out_valid;
    t_result       r_res, n_res;

    logic          w_accept;
    logic          w_pop_go;
    logic          w_mem_we;
    logic          w_mem_re;
    logic [PW-1:0] w_mem_addr;
    t_entry        w_wentry;
    t_entry        w_rentry;
    logic [PW+PEND_W-1:0] w_pend_ext;
    logic [PW+PEND_W-1:0] w_cnt_ext;

    flr_mem #(
        .DEPTH (LOG_DEPTH),
        .DATA_W(ENTRY_W)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_mem_we),
        .i_re   (w_mem_re),
        .i_addr (w_mem_addr),
        .i_wdata(w_wentry),
        .o_rdata(w_rentry)
    );

    assign w_wentry = '{module_id:  i_req.module_id,
                        severity:   i_req.severity,
                        fault_code: i_req.fault_code,
                        payload:    i_req.payload,
                        now_ms:     i_req.now_ms};

    assign i_req.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        n_state     = r_state;
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_count     = r_count;
        n_drop      = r_drop;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_res       = r_res;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_addr  = r_wr;
        w_pop_go    = 1'b0;

        // entry read issued last cycle is now on the memory output
        if (r_state == S_READ) begin
            w_cnt_ext               = {{PEND_W{1'b0}}, r_count};
            n_out_valid             = 1'b1;
            n_res.pop_valid         = 1'b1;
            n_res.popped_module     = w_rentry.module_id;
            n_res.popped_severity   = w_rentry.severity;
            n_res.popped_code       = w_rentry.fault_code;
            n_res.popped_payload    = w_rentry.payload;
            n_res.popped_time       = w_rentry.now_ms;
            n_res.pending           = w_cnt_ext[PEND_W-1:0];
            n_res.dropped           = r_drop;
            n_state                 = S_IDLE;
        end else begin
            w_cnt_ext = '0;
        end

        if (w_accept) begin
            case (t_action'(i_req.action))
                ACT_RECORD: begin
                    w_mem_we   = 1'b1;
                    w_mem_addr = r_wr;
                    n_wr       = (r_wr == LAST) ? '0 : r_wr + 1'b1;
                    if (r_count == LAST) begin
                        // full at LOG_DEPTH-1 entries: the oldest entry is dropped
                        n_rd   = (r_rd == LAST) ? '0 : r_rd + 1'b1;
                        n_drop = r_drop + 32'd1;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                ACT_POP: begin
                    if (r_count != '0) begin
                        w_pop_go   = 1'b1;
                        w_mem_re   = 1'b1;
                        w_mem_addr = r_rd;
                        n_rd       = (r_rd == LAST) ? '0 : r_rd + 1'b1;
                        n_count    = r_count - 1'b1;
                        n_state    = S_READ;
                    end
                end
                ACT_CLEAR: begin
                    n_wr    = '0;
                    n_rd    = '0;
                    n_count = '0;
                    n_drop  = '0;
                end
                default: begin
                end
            endcase
        end

        w_pend_ext = {{PEND_W{1'b0}}, n_count};
        if (w_accept && !w_pop_go) begin
            n_out_valid = 1'b1;
            n_res       = '0;
            n_res.pending = w_pend_ext[PEND_W-1:0];
            n_res.dropped = n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr        <= '0;
            r_rd        <= '0;
            r_count     <= '0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.pop_valid       = r_res.pop_valid;
    assign o_rsp.popped_module   = r_res.popped_module;
    assign o_rsp.popped_severity = r_res.popped_severity;
    assign o_rsp.popped_code     = r_res.popped_code;
    assign o_rsp.popped_payload  = r_res.popped_payload;
    assign o_rsp.popped_time     = r_res.popped_time;
    assign o_rsp.pending         = r_res.pending;
    assign o_rsp.dropped         = r_res.dropped;

endmodule

`default_nettype wire

// ===== hw/rtl/flr_mem.sv =====
// single port entry memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module flr_mem #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 79
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/flr_chk.sv =====
// port level checks for the fault event ring log, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module flr_chk
    import flr_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic [1:0]  i_req_action,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic        i_pop_valid,
    input wire logic [3:0]  i_popped_module,
    input wire logic [31:0] i_popped_payload,
    input wire logic [31:0] i_popped_time,
    input wire logic [3:0]  i_pending,
    input wire logic [31:0] i_dropped
);

    logic w_req_acc;
    assign w_req_acc = i_req_valid && i_req_ready;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_pop_valid)
            && $stable(i_pending) && $stable(i_dropped))
        else $error("result changed while stalled");

    // anything but a pop answers in the next cycle
    a_fast_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_acc && i_req_action != ACT_POP |=> i_rsp_valid)
        else $error("non-pop request gave no result in one cycle");

    // clear empties the log and zeroes the drop counter
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_acc && i_req_action == ACT_CLEAR |=> i_rsp_valid && i_pending == 4'd0
            && i_dropped == 32'd0)
        else $error("clear did not empty the log");

    // a result without an entry carries zero entry fields
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_pop_valid |-> i_popped_module == 4'd0
            && i_popped_payload == 32'd0 && i_popped_time == 32'd0)
        else $error("entry fields set without a popped entry");

endmodule

bind fault_log_ring_drop_oldest flr_chk u_flr_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_req_action    (i_req.action),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_pop_valid     (o_rsp.pop_valid),
    .i_popped_module (o_rsp.popped_module),
    .i_popped_payload(o_rsp.popped_payload),
    .i_popped_time   (o_rsp.popped_time),
    .i_pending       (o_rsp.pending),
    .i_dropped       (o_rsp.dropped)
);

`default_nettype wire
